[design/uhk_pkg.sv]
package uhk_pkg;

    // One input request: a raw text byte and the end-of-text flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } uhk_in_t;

    // One output request: a re-encoded byte or an error status.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       run_last;
        logic       text_done;
    } uhk_out_t;

    // Status codes carried in the status field.
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_LEAD  = 3'd1;
    localparam logic [2:0] STATUS_BAD_CONT  = 3'd2;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd3;
    localparam logic [2:0] STATUS_BAD_POINT = 3'd4;

    // Hiragana range and the offset that maps it onto katakana.
    localparam logic [20:0] KANA_FIRST = 21'h003041;
    localparam logic [20:0] KANA_LAST  = 21'h003096;
    localparam logic [20:0] KANA_SHIFT = 21'h000060;

    // Code point limits.
    localparam logic [20:0] POINT_MAX      = 21'h10FFFF;
    localparam logic [20:0] SURROGATE_LOW  = 21'h00D800;
    localparam logic [20:0] SURROGATE_HIGH = 21'h00DFFF;
    localparam logic [20:0] LIMIT_ONE      = 21'h000080;
    localparam logic [20:0] LIMIT_TWO      = 21'h000800;
    localparam logic [20:0] LIMIT_THREE    = 21'h010000;

    // One unit of work handed from the decoder to the encoder.
    typedef struct packed {
        logic        is_err;
        logic [2:0]  status;
        logic [20:0] point;
        logic        text_end;
    } uhk_job_t;

    // Queue write port: a job and its strobe.
    typedef struct packed {
        logic     valid;
        uhk_job_t job;
    } uhk_push_t;

endpackage

[design/uhk_front.sv]
module uhk_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  uhk_pkg::uhk_in_t in_data,
    output uhk_pkg::uhk_push_t push
);

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  pending_reg, pending_next;
    logic [2:0]  seqlen_reg, seqlen_next;
    logic        dropping_reg, dropping_next;

    logic [20:0] part_n;
    logic [1:0]  pend_n;
    logic [2:0]  len_n;
    logic        err;
    logic [2:0]  err_status;
    logic        complete;
    logic        overlong;
    logic        bad_point;
    logic [20:0] point_out;
    logic [7:0]  b;

    assign b = in_data.in_byte;

    // Decode the byte against the current sequence state.
    always_comb
    begin
        err        = 1'b0;
        err_status = uhk_pkg::STATUS_OK;
        part_n     = partial_reg;
        pend_n     = pending_reg;
        len_n      = seqlen_reg;
        if (pending_reg == 2'd0)
        begin
            priority if (b[7] == 1'b0)
            begin
                part_n = {13'd0, b};
                len_n  = 3'd1;
                pend_n = 2'd0;
            end
            else if (b[7:5] == 3'b110)
            begin
                part_n = {16'd0, b[4:0]};
                len_n  = 3'd2;
                pend_n = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                part_n = {17'd0, b[3:0]};
                len_n  = 3'd3;
                pend_n = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                part_n = {18'd0, b[2:0]};
                len_n  = 3'd4;
                pend_n = 2'd3;
            end
            else
            begin
                err        = 1'b1;
                err_status = uhk_pkg::STATUS_BAD_LEAD;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            err        = 1'b1;
            err_status = uhk_pkg::STATUS_BAD_CONT;
        end
        else
        begin
            part_n = {partial_reg[14:0], b[5:0]};
            pend_n = pending_reg - 2'd1;
        end

        // A sequence cut off by the end of the text.
        if (!err && pend_n != 2'd0 && in_data.text_end)
        begin
            err        = 1'b1;
            err_status = uhk_pkg::STATUS_TRUNCATED;
        end

        // Check the finished code point.
        overlong  = (len_n == 3'd2 && part_n < uhk_pkg::LIMIT_ONE) ||
                    (len_n == 3'd3 && part_n < uhk_pkg::LIMIT_TWO) ||
                    (len_n == 3'd4 && part_n < uhk_pkg::LIMIT_THREE);
        bad_point = (part_n > uhk_pkg::POINT_MAX) ||
                    (part_n >= uhk_pkg::SURROGATE_LOW &&
                     part_n <= uhk_pkg::SURROGATE_HIGH) || overlong;
        complete  = !err && pend_n == 2'd0;
        if (complete && bad_point)
        begin
            err        = 1'b1;
            err_status = uhk_pkg::STATUS_BAD_POINT;
            complete   = 1'b0;
        end

        // Hiragana is moved up to katakana.
        if (part_n >= uhk_pkg::KANA_FIRST && part_n <= uhk_pkg::KANA_LAST)
            point_out = part_n + uhk_pkg::KANA_SHIFT;
        else
            point_out = part_n;
    end

    // Job handed to the queue.
    always_comb
    begin
        push.valid        = accept && !dropping_reg && (err || complete);
        push.job.is_err   = err;
        push.job.status   = err_status;
        push.job.point    = err ? 21'd0 : point_out;
        push.job.text_end = in_data.text_end;
    end

    // Next decoder state.
    always_comb
    begin
        partial_next  = partial_reg;
        pending_next  = pending_reg;
        seqlen_next   = seqlen_reg;
        dropping_next = dropping_reg;
        if (accept)
        begin
            if (dropping_reg)
            begin
                if (in_data.text_end)
                    dropping_next = 1'b0;
            end
            else if (err || complete)
            begin
                partial_next  = 21'd0;
                pending_next  = 2'd0;
                seqlen_next   = 3'd0;
                dropping_next = err && !in_data.text_end;
            end
            else
            begin
                partial_next = part_n;
                pending_next = pend_n;
                seqlen_next  = len_n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= 21'd0;
            pending_reg  <= 2'd0;
            seqlen_reg   <= 3'd0;
            dropping_reg <= 1'b0;
        end
        else
        begin
            partial_reg  <= partial_next;
            pending_reg  <= pending_next;
            seqlen_reg   <= seqlen_next;
            dropping_reg <= dropping_next;
        end
    end

    // A sequence in progress is always longer than what it still waits for.
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd0 |-> seqlen_reg > {1'b0, pending_reg})
        else $error("pending count exceeds sequence length");

    // While dropping, no sequence is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> pending_reg == 2'd0 && seqlen_reg == 3'd0)
        else $error("decoder state kept while dropping");

    // An error before the end of the text starts dropping.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && push.job.is_err && !in_data.text_end |=> dropping_reg)
        else $error("dropping not entered after error");

endmodule

[design/uhk_queue.sv]
module uhk_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  uhk_pkg::uhk_push_t push,
    input  logic               pop,
    output uhk_pkg::uhk_job_t  head,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uhk_pkg::uhk_job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = count_reg == CNT_W'(0);
    assign full    = count_reg == CNT_W'(DEPTH);
    assign do_push = push.valid;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The decoder never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.valid)
        else $error("write into full queue");

endmodule

[design/uhk_back.sv]
module uhk_back (
    input  logic               clk,
    input  logic               rst_n,
    input  uhk_pkg::uhk_job_t  head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output uhk_pkg::uhk_out_t  out_data
);

    uhk_pkg::uhk_job_t cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [1:0]        idx_reg, idx_next;
    uhk_pkg::uhk_out_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [1:0] last_idx;
    logic [1:0] chunk_sel;
    logic [5:0] chunk;
    logic [7:0] lead;
    logic [7:0] byte_val;
    logic       is_last;
    logic       out_load;

    // Byte count of the current job, as the index of its last byte.
    always_comb
    begin
        priority if (cur_reg.is_err)
            last_idx = 2'd0;
        else if (cur_reg.point < uhk_pkg::LIMIT_ONE)
            last_idx = 2'd0;
        else if (cur_reg.point < uhk_pkg::LIMIT_TWO)
            last_idx = 2'd1;
        else if (cur_reg.point < uhk_pkg::LIMIT_THREE)
            last_idx = 2'd2;
        else
            last_idx = 2'd3;
    end

    // Select the byte at the current position of the encoding.
    always_comb
    begin
        unique case (last_idx)
            2'd0:    lead = cur_reg.point[7:0];
            2'd1:    lead = {3'b110, cur_reg.point[10:6]};
            2'd2:    lead = {4'b1110, cur_reg.point[15:12]};
            default: lead = {5'b11110, cur_reg.point[20:18]};
        endcase
        chunk_sel = last_idx - idx_reg;
        unique case (chunk_sel)
            2'd0:    chunk = cur_reg.point[5:0];
            2'd1:    chunk = cur_reg.point[11:6];
            default: chunk = cur_reg.point[17:12];
        endcase
        if (cur_reg.is_err)
            byte_val = 8'd0;
        else if (idx_reg == 2'd0)
            byte_val = lead;
        else
            byte_val = {2'b10, chunk};
    end

    assign is_last  = idx_reg == last_idx;
    assign out_load = cur_valid_reg && (!out_valid_reg || out_ready);
    assign pop      = !empty && (!cur_valid_reg || (out_load && is_last));

    // Current job and byte position.
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_next       = head;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (out_load && is_last)
            cur_valid_next = 1'b0;
        else if (out_load)
            idx_next = idx_reg + 2'd1;
    end

    // Output register.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_next.out_byte  = byte_val;
            out_next.status    = cur_reg.is_err ? cur_reg.status : uhk_pkg::STATUS_OK;
            out_next.run_last  = is_last;
            out_next.text_done = is_last && cur_reg.text_end;
            out_valid_next     = 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The byte position never runs past the end of the encoding.
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg <= last_idx)
        else $error("byte position beyond encoding length");

endmodule

[design/utf8_hiragana_to_katakana_unit.sv]
// UTF-8 transcoder that turns hiragana into katakana. Input requests carry one text
// byte and an end-of-text flag; a request is taken every cycle while the job
// queue has room. The decoder checks each byte in the cycle it arrives and writes
// one job per completed code point or error; the encoder then sends one output
// byte per cycle unless the output stalls, 1 to 4 per code point and a single
// status request per error, so valid text leaves with as many bytes as it came
// in with. A job passes through the queue and the current-job register before it
// reaches the output register. After an error the rest of the text is dropped.
module utf8_hiragana_to_katakana_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  uhk_pkg::uhk_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output uhk_pkg::uhk_out_t out_data
);

    uhk_pkg::uhk_push_t push;
    uhk_pkg::uhk_job_t  head;
    logic               empty;
    logic               full;
    logic               pop;
    logic               accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // Byte decoder and validator.
    uhk_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .push    (push)
    );

    // Job queue between decoder and encoder.
    uhk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .empty (empty),
        .full  (full)
    );

    // Encoder and output register.
    uhk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
